[rtl/core/cmbb_pkg.sv]
// Shared types and constants for the clipped mask blit and blend core.
// Holds item and register codes, blend modes, controller state and
// the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package cmbb_pkg;

	// default store geometry
	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	// saturation ceiling for additive blending
	localparam logic [7:0] SAT_MAX = 8'd31;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 3'd6;

	// item kinds
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// blend modes
	localparam logic [1:0] MODE_COPY = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_SUB  = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic capture;
		logic clear_step;
		logic update;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic read_pending;
		logic out_busy;
	} dp_sts_t;

endpackage

[rtl/core/cmbb_if.sv]
// Valid/ready channel interfaces for the blit core: item input and result output.
// Standalone; carries the payload fields at their fixed widths.
`timescale 1ns / 1ps

interface cmbb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] pixel_value;
	logic [6:0] entry_row;
	logic [6:0] entry_col;

	modport source (output valid, kind, pixel_value, entry_row, entry_col, input ready);
	modport sink   (input valid, kind, pixel_value, entry_row, entry_col, output ready);
endinterface

interface cmbb_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_value;

	modport source (output valid, read_value, input ready);
	modport sink   (input valid, read_value, output ready);
endinterface

[rtl/core/cmbb_ctrl.sv]
// Sequencing state machine of the blit core: clear sweep, accept, fetch, update.
// Depends on cmbb_pkg for state and command/status types.
`timescale 1ns / 1ps

module cmbb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  cmbb_pkg::dp_sts_t    sts,
	output cmbb_pkg::ctrl_cmd_t  cmd
);
	import cmbb_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold a read transaction while the result register is still occupied
				if (!(sts.read_pending && sts.out_busy)) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/cmbb_dp.sv]
// Datapath of the blit core: registers, scan counters, clip and address logic,
// destination store, blend unit and result register. Depends on cmbb_pkg.
`timescale 1ns / 1ps

module cmbb_dp #(
	parameter int MAX_WIDTH  = cmbb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cmbb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmbb_pkg::ctrl_cmd_t             cmd,
	output cmbb_pkg::dp_sts_t               sts,
	input  logic                            cfg_we,
	input  logic [cmbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      pixel_value,
	input  logic [6:0]                      entry_row,
	input  logic [6:0]                      entry_col,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      read_value
);
	import cmbb_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int POS_W  = ((CNT_W > 9) ? CNT_W : 9) + 2;
	localparam int LIN_W  = ADDR_W + 8;

	// configuration registers
	logic [7:0]        dest_width_q, dest_height_q, src_width_q, src_height_q;
	logic signed [8:0] offset_x_q, offset_y_q;
	logic [1:0]        blend_mode_q;

	// scan counters
	logic [COL_W-1:0]  col_cnt_q;
	logic [ROW_W-1:0]  row_cnt_q;

	// captured item
	logic [ADDR_W-1:0] addr_q;
	logic [1:0]        kind_q;
	logic [7:0]        pix_q;
	logic              hit_q;

	// store and clear sweep
	logic [7:0]        mem [DEPTH];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// result register
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	// effective sizes
	logic [POS_W-1:0]  dw, dh, sw, sh;
	logic signed [POS_W-1:0] pos_r, pos_c;
	logic              blit_hit, dir_hit, cfg_hit;
	logic [LIN_W-1:0]  blit_lin, dir_lin;
	logic              col_wrap, row_wrap;
	logic [8:0]        sum;
	logic [7:0]        blended;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;

	// clamp sizes to the store geometry; a zero source size scans as one
	always_comb begin
		dw = (POS_W'(dest_width_q) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) :
			POS_W'(dest_width_q);
		dh = (POS_W'(dest_height_q) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) :
			POS_W'(dest_height_q);
		sw = (POS_W'(src_width_q) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) :
			POS_W'(src_width_q);
		sh = (POS_W'(src_height_q) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) :
			POS_W'(src_height_q);
		if (src_width_q == 8'd0) begin
			sw = POS_W'(1);
		end
		if (src_height_q == 8'd0) begin
			sh = POS_W'(1);
		end
	end

	// place the source pixel and clip against the destination window
	always_comb begin
		pos_r = POS_W'(offset_y_q) + POS_W'($signed({1'b0, row_cnt_q}));
		pos_c = POS_W'(offset_x_q) + POS_W'($signed({1'b0, col_cnt_q}));
		blit_hit = !pos_r[POS_W-1] && !pos_c[POS_W-1] &&
			($unsigned(pos_r) < dh) && ($unsigned(pos_c) < dw);
		blit_lin = LIN_W'(pos_r[ROW_W-1:0]) * LIN_W'(MAX_WIDTH) + LIN_W'(pos_c[COL_W-1:0]);
		dir_hit  = (POS_W'(entry_row) < POS_W'(MAX_HEIGHT)) &&
			(POS_W'(entry_col) < POS_W'(MAX_WIDTH));
		dir_lin  = LIN_W'(entry_row) * LIN_W'(MAX_WIDTH) + LIN_W'(entry_col);
		col_wrap = (POS_W'(col_cnt_q) + POS_W'(1)) >= sw;
		row_wrap = (POS_W'(row_cnt_q) + POS_W'(1)) >= sh;
		cfg_hit  = cfg_we && (cfg_index <= REG_BLEND_MODE);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q  <= 8'd128;
			dest_height_q <= 8'd128;
			src_width_q   <= 8'd128;
			src_height_q  <= 8'd128;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			blend_mode_q  <= MODE_COPY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_WIDTH:  dest_width_q  <= cfg_data[7:0];
				REG_DEST_HEIGHT: dest_height_q <= cfg_data[7:0];
				REG_SRC_WIDTH:   src_width_q   <= cfg_data[7:0];
				REG_SRC_HEIGHT:  src_height_q  <= cfg_data[7:0];
				REG_OFFSET_X:    offset_x_q    <= $signed(cfg_data);
				REG_OFFSET_Y:    offset_y_q    <= $signed(cfg_data);
				REG_BLEND_MODE:  blend_mode_q  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// advance the raster scan; restart it on any write to a defined register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (cfg_hit) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (cmd.capture && (kind == KIND_PIXEL)) begin
			if (col_wrap) begin
				col_cnt_q <= '0;
				row_cnt_q <= row_wrap ? '0 : row_cnt_q + 1'b1;
			end else begin
				col_cnt_q <= col_cnt_q + 1'b1;
			end
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_PIXEL;
		end else if (cmd.capture) begin
			kind_q <= kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel_value;
			if (kind == KIND_PIXEL) begin
				hit_q  <= blit_hit;
				addr_q <= blit_lin[ADDR_W-1:0];
			end else begin
				hit_q  <= dir_hit;
				addr_q <= dir_lin[ADDR_W-1:0];
			end
		end
	end

	// sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// blend the fetched entry with the source pixel
	always_comb begin
		sum = {1'b0, rdata_q} + {1'b0, pix_q};
		unique case (blend_mode_q)
			MODE_ADD: blended = (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[7:0];
			MODE_SUB: blended = (rdata_q >= pix_q) ? (rdata_q - pix_q) : 8'd0;
			default:  blended = pix_q;
		endcase
	end

	// store write port
	always_comb begin
		mem_we = cmd.clear_step ||
			(cmd.update && hit_q && ((kind_q == KIND_PIXEL) || (kind_q == KIND_WRITE)));
		mem_wa = cmd.clear_step ? clr_addr_q : addr_q;
		if (cmd.clear_step) begin
			mem_wd = 8'd0;
		end else if (kind_q == KIND_WRITE) begin
			mem_wd = pix_q;
		end else begin
			mem_wd = blended;
		end
	end

	// destination store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[addr_q];
	end

	// result register; an address outside the store reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update && (kind_q == KIND_READ)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && (kind_q == KIND_READ)) begin
			out_data_q <= hit_q ? rdata_q : 8'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_data_q;

	assign sts.clear_done   = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.read_pending = (kind_q == KIND_READ);
	assign sts.out_busy     = out_valid_q && !out_ready;

endmodule

[rtl/core/clipped_mask_blit_blend_core.sv]
// Top level of the clipped mask blit and blend core: controller plus datapath.
// Depends on cmbb_pkg, cmbb_if, cmbb_ctrl and cmbb_dp.
// After reset the block zeroes its MAX_WIDTH*MAX_HEIGHT-entry destination store, one
// entry per cycle, and accepts no item until that sweep ends; register writes are
// taken throughout. Each item then passes through accept and address calculation,
// a registered read of the store, then the blend and write back or the load of the
// result register. A read transaction that finds the result register still occupied
// waits in the last step. Source pixels are placed by an internal raster scan that
// restarts on every write to a defined register; pixels falling outside the
// destination window are dropped without touching the store.
`timescale 1ns / 1ps

module clipped_mask_blit_blend_core #(
	parameter int MAX_WIDTH  = cmbb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cmbb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cmbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmbb_pkg::CFG_DATA_W-1:0] cfg_data,
	cmbb_item_if.sink                       item,
	cmbb_result_if.source                   result
);
	import cmbb_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	cmbb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	cmbb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (item.kind),
		.pixel_value (item.pixel_value),
		.entry_row   (item.entry_row),
		.entry_col   (item.entry_col),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.read_value  (result.read_value)
	);

	assign item.ready = cmd.in_ready;

	// one transaction in flight: no accept right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while another is in flight");

	// a fresh result follows a read transaction through the fetch and update states
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(item.valid && item.ready && (item.kind == KIND_READ), 3))
		else $error("result without a matching read transaction");

	// the clear sweep never overlaps with an accept or with a valid result
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !item.ready && !result.valid)
		else $error("transaction activity during the clear sweep");

endmodule

[test/cmbb_blit_checker.sv]
// Checker for the clipped mask blit and blend core: watches the register port and both
// channels, keeps its own copy of the destination mask and raster scan, and scores reads.
// Depends on cmbb_pkg and the channel interfaces in cmbb_if.
`timescale 1ns / 1ps

module cmbb_blit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cmbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmbb_pkg::CFG_DATA_W-1:0] cfg_data,
	cmbb_item_if                            item,
	cmbb_result_if                          result,
	output int                              fail_count,
	output int                              pending
);
	import cmbb_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	// predicted destination mask and scan position
	logic [7:0]        dest_mask [0:STORE_DEPTH-1];
	int                row_pos;
	int                col_pos;

	// shadow copy of the registers, raw as written
	logic [7:0]        dst_w;
	logic [7:0]        dst_h;
	logic [7:0]        src_w;
	logic [7:0]        src_h;
	logic signed [8:0] off_x;
	logic signed [8:0] off_y;
	logic [1:0]        mode;

	// read values still owed by the block, oldest first
	logic [7:0]        read_values_due [$];
	logic [7:0]        due_value;

	function automatic logic [7:0] blend_pixel(input logic [7:0] stored, input logic [7:0] pix,
			input logic [1:0] m);
		int acc;
		case (m)
			MODE_ADD: begin
				acc = int'(stored) + int'(pix);
				return (acc > int'(SAT_MAX)) ? SAT_MAX : 8'(acc);
			end
			MODE_SUB: begin
				acc = int'(stored) - int'(pix);
				return (acc < 0) ? 8'd0 : 8'(acc);
			end
			// copy, and the unused fourth mode as copy
			default: return pix;
		endcase
	endfunction

	function automatic int clamp_dim(input logic [7:0] v, input int lim, input bit zero_as_one);
		if (int'(v) > lim)
			return lim;
		if (v == 8'd0 && zero_as_one)
			return 1;
		return int'(v);
	endfunction

	task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_DEST_WIDTH:  dst_w = val[7:0];
			REG_DEST_HEIGHT: dst_h = val[7:0];
			REG_SRC_WIDTH:   src_w = val[7:0];
			REG_SRC_HEIGHT:  src_h = val[7:0];
			REG_OFFSET_X:    off_x = val;
			REG_OFFSET_Y:    off_y = val;
			REG_BLEND_MODE:  mode  = val[1:0];
			default:         return;
		endcase
		// any real register write restarts the scan
		row_pos = 0;
		col_pos = 0;
	endtask

	task automatic place_pixel(input logic [7:0] pix);
		int dw, dh, sw, sh, r, c, addr;
		dw = clamp_dim(dst_w, DEF_MAX_WIDTH, 1'b0);
		dh = clamp_dim(dst_h, DEF_MAX_HEIGHT, 1'b0);
		sw = clamp_dim(src_w, DEF_MAX_WIDTH, 1'b1);
		sh = clamp_dim(src_h, DEF_MAX_HEIGHT, 1'b1);
		r = int'(off_y) + row_pos;
		c = int'(off_x) + col_pos;
		// clip against the destination window
		if (r >= 0 && c >= 0 && r < dh && c < dw) begin
			addr = r * DEF_MAX_WIDTH + c;
			dest_mask[addr] = blend_pixel(dest_mask[addr], pix, mode);
		end
		// advance the raster scan, dropped pixels included
		if (col_pos + 1 >= sw) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic apply_item(input logic [1:0] k, input logic [7:0] pix, input logic [6:0] row,
			input logic [6:0] col);
		int addr;
		addr = int'(row) * DEF_MAX_WIDTH + int'(col);
		case (k)
			KIND_PIXEL: place_pixel(pix);
			KIND_WRITE: dest_mask[addr] = pix;
			KIND_READ:  read_values_due.push_back(dest_mask[addr]);
			default:    ;
		endcase
	endtask

	// track every transaction in acceptance order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				dest_mask[i] = 8'd0;
			dst_w = 8'd128;
			dst_h = 8'd128;
			src_w = 8'd128;
			src_h = 8'd128;
			off_x = '0;
			off_y = '0;
			mode = MODE_COPY;
			row_pos = 0;
			col_pos = 0;
			read_values_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				load_register(cfg_index, cfg_data);
			if (result.valid && result.ready) begin
				if (read_values_due.size() == 0) begin
					fail_count++;
					$display("%0t: read_value expected none actual %0d", $time, result.read_value);
				end else begin
					due_value = read_values_due.pop_front();
					if (result.read_value !== due_value) begin
						fail_count++;
						$display("%0t: read_value expected %0d actual %0d", $time, due_value,
							result.read_value);
					end
				end
			end
			if (item.valid && item.ready)
				apply_item(item.kind, item.pixel_value, item.entry_row, item.entry_col);
			pending = read_values_due.size();
		end
	end

endmodule

[test/clipped_mask_blit_blend_core_tb.sv]
// Top of the blit core testbench: clock, reset, register writes, item stimulus and the verdict.
// Depends on cmbb_pkg, cmbb_if, the core and cmbb_blit_checker.
`timescale 1ns / 1ps

module clipped_mask_blit_blend_core_tb;
	import cmbb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] MODE_ALT  = 2'd3;

	localparam int RANDOM_ITEMS  = 500;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_BLIT      = 48;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cmbb_item_if   item_ch ();
	cmbb_result_if result_ch ();

	int fail_count;
	int pending;

	// idle rates in percent per cycle, and the long receiver hold-off
	int send_gap_pct;
	int recv_gap_pct;
	bit hold_req;
	int hold_left;

	// item count, ignored kinds excluded
	int items_sent;

	// shadow of the scan geometry for shaping reads
	logic [7:0] sh_src_w;
	logic [7:0] sh_src_h;
	int         sh_off_x;
	int         sh_off_y;

	clipped_mask_blit_blend_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	cmbb_blit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result ready: random stalls, or a long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	function automatic int scan_dim(input logic [7:0] v);
		if (v == 8'd0)
			return 1;
		return (int'(v) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(v);
	endfunction

	// offer one item, idling before it at the current rate, and wait for the transaction
	task automatic send_item(input logic [1:0] k, input logic [7:0] pix, input logic [6:0] row,
			input logic [6:0] col);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.kind        <= k;
		item_ch.pixel_value <= pix;
		item_ch.entry_row   <= row;
		item_ch.entry_col   <= col;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (k != KIND_NONE)
			items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:  sh_src_w = val[7:0];
			REG_SRC_HEIGHT: sh_src_h = val[7:0];
			REG_OFFSET_X:   sh_off_x = int'($signed(val));
			REG_OFFSET_Y:   sh_off_y = int'($signed(val));
			default:        ;
		endcase
	endtask

	// drop valid, wait for every read result, then let writes and pixels retire
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_size(input int small_max);
		int r;
		r = $urandom_range(0, 11);
		case (r)
			0:       return 8'd0;
			1:       return 8'd128;
			2:       return 8'($urandom_range(129, 255));
			3:       return 8'd1;
			default: return 8'($urandom_range(1, small_max));
		endcase
	endfunction

	function automatic logic [8:0] pick_offset();
		int r;
		r = $urandom_range(0, 11);
		case (r)
			0:       return 9'h100;
			1:       return 9'h0FF;
			2:       return 9'(-128);
			3:       return 9'd128;
			default: return 9'($urandom_range(0, 16) - 8);
		endcase
	endfunction

	// new phase setup: blend mode always, a random subset of the other registers, extremes now and then
	task automatic shuffle_setup();
		write_reg(REG_BLEND_MODE, 9'($urandom_range(0, 3)));
		if ($urandom_range(1))
			write_reg(REG_DEST_WIDTH, 9'(pick_size(20)));
		if ($urandom_range(1))
			write_reg(REG_DEST_HEIGHT, 9'(pick_size(20)));
		if ($urandom_range(1))
			write_reg(REG_SRC_WIDTH, 9'(pick_size(8)));
		if ($urandom_range(1))
			write_reg(REG_SRC_HEIGHT, 9'(pick_size(8)));
		if ($urandom_range(1))
			write_reg(REG_OFFSET_X, pick_offset());
		if ($urandom_range(1))
			write_reg(REG_OFFSET_Y, pick_offset());
		if ($urandom_range(0, 15) == 0)
			write_reg(REG_UNUSED, 9'($urandom));
	endtask

	// one blit of random content with an occasional direct write, then reads around where it landed
	task automatic run_blit();
		int sw, sh, n_pix, n_rd, dr, dc;
		sw = scan_dim(sh_src_w);
		sh = scan_dim(sh_src_h);
		n_pix = (sw * sh > MAX_BLIT) ? MAX_BLIT : sw * sh;
		for (int i = 0; i < n_pix; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(KIND_WRITE, 8'($urandom), 7'($urandom), 7'($urandom));
			if ($urandom_range(1))
				send_item(KIND_PIXEL, 8'($urandom_range(0, 40)), 7'($urandom), 7'($urandom));
			else
				send_item(KIND_PIXEL, 8'($urandom), 7'($urandom), 7'($urandom));
		end
		n_rd = $urandom_range(2, 6);
		for (int i = 0; i < n_rd; i++) begin
			dr = $urandom_range(0, sh - 1);
			dc = $urandom_range(0, sw - 1);
			send_item(KIND_READ, 8'($urandom), 7'(sh_off_y + dr), 7'(sh_off_x + dc));
		end
	endtask

	initial begin
		int base, done_cnt, guard;
		bit pressure_done;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_PIXEL;
		item_ch.pixel_value = '0;
		item_ch.entry_row = '0;
		item_ch.entry_col = '0;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_req = 1'b0;
		items_sent = 0;
		sh_src_w = 8'd128;
		sh_src_h = 8'd128;
		sh_off_x = 0;
		sh_off_y = 0;
		pressure_done = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// cleared store and direct access at the corners
		send_item(KIND_READ, 8'h00, 7'd0, 7'd0);
		send_item(KIND_WRITE, 8'hFF, 7'd127, 7'd127);
		send_item(KIND_WRITE, 8'h5A, 7'd127, 7'd0);
		send_item(KIND_READ, 8'hFF, 7'd127, 7'd127);
		send_item(KIND_READ, 8'h00, 7'd127, 7'd0);
		send_item(KIND_NONE, 8'hFF, 7'd127, 7'd127);
		// copy from the scan origin
		send_item(KIND_PIXEL, 8'h55, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'hFF, 7'd127, 7'd127);
		send_item(KIND_READ, 8'h00, 7'd0, 7'd1);
		drain();

		// add saturates at the ceiling, also when the entry is already above it
		write_reg(REG_BLEND_MODE, 9'(MODE_ADD));
		write_reg(REG_SRC_WIDTH, 9'd2);
		send_item(KIND_WRITE, 8'd200, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'd1, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'd255, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'd7, 7'd0, 7'd0);
		send_item(KIND_READ, 8'd0, 7'd0, 7'd0);
		send_item(KIND_READ, 8'd0, 7'd1, 7'd0);
		drain();

		// subtract floors at zero; a zero source size scans one pixel
		write_reg(REG_BLEND_MODE, 9'(MODE_SUB));
		write_reg(REG_SRC_WIDTH, 9'd0);
		write_reg(REG_SRC_HEIGHT, 9'd0);
		send_item(KIND_PIXEL, 8'd10, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'd255, 7'd0, 7'd0);
		send_item(KIND_READ, 8'd0, 7'd0, 7'd0);
		drain();

		// zero destination width drops everything, here with the fourth mode set
		write_reg(REG_DEST_WIDTH, 9'd0);
		write_reg(REG_BLEND_MODE, 9'(MODE_ALT));
		send_item(KIND_PIXEL, 8'h77, 7'd0, 7'd0);
		send_item(KIND_READ, 8'd0, 7'd0, 7'd0);
		drain();

		// unused index, oversized sizes, offsets at the far corner
		write_reg(REG_UNUSED, 9'h1FF);
		write_reg(REG_DEST_WIDTH, 9'd255);
		write_reg(REG_DEST_HEIGHT, 9'd200);
		write_reg(REG_SRC_WIDTH, 9'd255);
		write_reg(REG_SRC_HEIGHT, 9'd129);
		write_reg(REG_OFFSET_X, 9'd127);
		write_reg(REG_OFFSET_Y, 9'd127);
		send_item(KIND_PIXEL, 8'h81, 7'd0, 7'd0);
		send_item(KIND_PIXEL, 8'h42, 7'd0, 7'd0);
		send_item(KIND_READ, 8'd0, 7'd127, 7'd127);

		// random phases over three idle profiles
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			done_cnt = items_sent - base;
			if (done_cnt < RANDOM_ITEMS / 3) begin
				send_gap_pct = 18;
				recv_gap_pct = 54;
			end else if (done_cnt < 2 * RANDOM_ITEMS / 3) begin
				send_gap_pct = 54;
				recv_gap_pct = 18;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			drain();
			shuffle_setup();
			// hold the result side off while reads keep coming
			if (!pressure_done && done_cnt >= RANDOM_ITEMS / 2) begin
				pressure_done = 1'b1;
				hold_req = 1'b1;
				repeat (24) send_item(KIND_READ, 8'($urandom), 7'($urandom), 7'($urandom));
			end
			if ($urandom_range(0, 9) < 7) begin
				run_blit();
			end else begin
				repeat (10) send_item(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
					7'($urandom));
			end
		end

		// wait out the last results, then the verdict
		@(negedge clk);
		item_ch.valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d read results never arrived", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/core/cmbb_pkg.sv
rtl/core/cmbb_if.sv
rtl/core/cmbb_ctrl.sv
rtl/core/cmbb_dp.sv
rtl/core/clipped_mask_blit_blend_core.sv
test/cmbb_blit_checker.sv
test/clipped_mask_blit_blend_core_tb.sv
